// ----- design/dvr_pkg.sv -----
// Package for the distance-vector route update block.
// Holds table geometry, field widths, command and status codes and the shared
// structs. No dependencies.
`default_nettype none

package dvr_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Field widths of the stream beats.
    localparam int DEST_W  = 8;
    localparam int DIST_W  = 5;
    localparam int HOP_W   = 8;
    localparam int RIDX_W  = 5;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int LIMIT_W = 5;

    // Common width for comparing a read index against the route count.
    localparam int RCMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    // Hop limit after reset.
    localparam logic [LIMIT_W-1:0] HOP_LIMIT_RST = LIMIT_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSTALL   = 2'd0,
        CMD_ADVERTISE = 2'd1,
        CMD_READ      = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_ADDED      = 3'd0,
        ST_UPDATED    = 3'd1,
        ST_UNCHANGED  = 3'd2,
        ST_OVER_LIMIT = 3'd3,
        ST_FULL       = 3'd4,
        ST_READ       = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RD_WAIT,
        S_SCAN,
        S_APPLY,
        S_DONE
    } t_state;

    // One stored route.
    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [DIST_W-1:0] distance;
        logic [HOP_W-1:0]  hop;
    } t_entry;

    // One input item.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DEST_W-1:0] dest;
        logic [DIST_W-1:0] distance;
        logic [HOP_W-1:0]  hop;
        logic [RIDX_W-1:0] ridx;
    } t_item;

    // One result item.
    typedef struct packed {
        t_status           status;
        logic              valid;
        logic [RIDX_W-1:0] index;
        t_entry            entry;
    } t_result;

    // Access request from the sequencer to the route table.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic             append;
    } t_tbl_req;

    function automatic t_result mk_result(t_status st, logic vld,
                                          logic [RIDX_W-1:0] idx, t_entry ent);
        t_result res;
        res.status = st;
        res.valid  = vld;
        res.index  = idx;
        res.entry  = ent;
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/dvr_table.sv -----
// Route table storage: one memory of routes with a registered read port,
// one write port, and the route count. Depends on dvr_pkg.
`default_nettype none

module dvr_table
    import dvr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_tbl_req         i_req,
    output t_entry                o_rd,
    output logic [CNT_W-1:0]      o_count
);

    t_entry           r_mem [TABLE_ENTRIES];
    t_entry           r_rd;
    logic [CNT_W-1:0] r_count;

    // Memory write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    // Number of routes held; entries are only ever appended.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_req.append) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign o_rd    = r_rd;
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- design/dvr_seq.sv -----
// Sequencer for the route update: scans the table one entry per cycle with a
// shared destination compare, then applies the distance-vector rules.
// Depends on dvr_pkg.
`default_nettype none

module dvr_seq
    import dvr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_item              i_item,
    input  wire logic [LIMIT_W-1:0] i_hop_limit,
    input  wire logic               i_res_ready,
    output logic                    o_res_valid,
    output t_result                 o_res,
    output t_tbl_req                o_tbl_req,
    input  wire t_entry             i_tbl_rd,
    input  wire logic [CNT_W-1:0]   i_tbl_count
);

    t_state            r_state;
    t_state            n_state;
    t_item             r_item;
    t_result           r_res;
    t_entry            r_ent;
    logic [CNT_W-1:0]  r_scan_idx;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [IDX_W-1:0]  r_hit_idx;
    logic              r_found;

    logic              adv_over;
    logic              rd_ok;
    t_result           imm_res;
    logic              issue;
    logic              hit;
    logic              scan_end;
    logic [DIST_W-1:0] new_dist;
    logic              ap_wr;
    logic              ap_app;
    logic [IDX_W-1:0]  ap_idx;
    t_entry            ap_ent;
    t_result           ap_res;

    // Checks made on the incoming item before any table access.
    assign adv_over = ((DIST_W + 1)'(i_item.distance) + (DIST_W + 1)'(1))
                      >= (DIST_W + 1)'(i_hop_limit);
    assign rd_ok    = RCMP_W'(i_item.ridx) < RCMP_W'(i_tbl_count);

    // Results that need no table access.
    always_comb begin
        case (t_cmd'(i_item.cmd))
            CMD_ADVERTISE: imm_res = mk_result(ST_OVER_LIMIT, 1'b0, '0, '0);
            CMD_READ:      imm_res = mk_result(ST_READ, 1'b0, i_item.ridx, '0);
            default:       imm_res = mk_result(ST_UNCHANGED, 1'b0, '0, '0);
        endcase
    end

    // Scan pipeline: address issued one cycle, compared the next.
    assign issue    = r_scan_idx < i_tbl_count;
    assign hit      = r_cmp_vld && (i_tbl_rd.dest == r_item.dest);
    assign scan_end = hit || (!issue && !r_cmp_vld);

    // Update rules applied once the scan has ended.
    assign new_dist = r_item.distance + DIST_W'(1);

    always_comb begin
        ap_wr  = 1'b0;
        ap_app = 1'b0;
        ap_idx = r_hit_idx;
        ap_ent = r_ent;
        ap_res = mk_result(ST_UNCHANGED, 1'b1, RIDX_W'(r_hit_idx), r_ent);
        if (!r_found) begin
            if (i_tbl_count == CNT_W'(TABLE_ENTRIES)) begin
                ap_res = mk_result(ST_FULL, 1'b0, '0, '0);
            end else begin
                ap_wr           = 1'b1;
                ap_app          = 1'b1;
                ap_idx          = IDX_W'(i_tbl_count);
                ap_ent.dest     = r_item.dest;
                ap_ent.distance = (t_cmd'(r_item.cmd) == CMD_INSTALL) ?
                                  r_item.distance : new_dist;
                ap_ent.hop      = r_item.hop;
                ap_res          = mk_result(ST_ADDED, 1'b1, RIDX_W'(ap_idx), ap_ent);
            end
        end else if (t_cmd'(r_item.cmd) == CMD_INSTALL) begin
            ap_wr           = 1'b1;
            ap_ent.distance = r_item.distance;
            ap_ent.hop      = r_item.hop;
            ap_res          = mk_result(ST_UPDATED, 1'b1, RIDX_W'(ap_idx), ap_ent);
        end else if (r_ent.hop == r_item.hop) begin
            // Same neighbor: always follow its distance.
            if (r_ent.distance != new_dist) begin
                ap_wr           = 1'b1;
                ap_ent.distance = new_dist;
                ap_res          = mk_result(ST_UPDATED, 1'b1, RIDX_W'(ap_idx), ap_ent);
            end
        end else if (new_dist < r_ent.distance) begin
            // Other neighbor: take the route only if strictly shorter.
            ap_wr           = 1'b1;
            ap_ent.distance = new_dist;
            ap_ent.hop      = r_item.hop;
            ap_res          = mk_result(ST_UPDATED, 1'b1, RIDX_W'(ap_idx), ap_ent);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_cmd'(i_item.cmd))
                        CMD_INSTALL:   n_state = S_SCAN;
                        CMD_ADVERTISE: n_state = adv_over ? S_DONE : S_SCAN;
                        CMD_READ:      n_state = rd_ok ? S_READ : S_DONE;
                        default:       n_state = S_DONE;
                    endcase
                end
            end
            S_READ:    n_state = S_RD_WAIT;
            S_RD_WAIT: n_state = S_DONE;
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY:   n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // State outputs and table requests.
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_tbl_req   = '0;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_READ: begin
                o_tbl_req.rd_en   = 1'b1;
                o_tbl_req.rd_addr = IDX_W'(r_item.ridx);
            end
            S_SCAN: begin
                o_tbl_req.rd_en   = issue;
                o_tbl_req.rd_addr = r_scan_idx[IDX_W-1:0];
            end
            S_APPLY: begin
                o_tbl_req.wr_en   = ap_wr;
                o_tbl_req.wr_addr = ap_idx;
                o_tbl_req.wr_data = ap_ent;
                o_tbl_req.append  = ap_app;
            end
            S_DONE: o_res_valid = 1'b1;
            default: o_tbl_req = '0;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item, scan and result registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_item     <= i_item;
                    r_scan_idx <= '0;
                    r_cmp_vld  <= 1'b0;
                    r_res      <= imm_res;
                end
            end
            S_SCAN: begin
                r_cmp_vld <= issue;
                r_cmp_idx <= r_scan_idx[IDX_W-1:0];
                if (issue) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
                if (hit) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                    r_ent     <= i_tbl_rd;
                end else if (scan_end) begin
                    r_found <= 1'b0;
                end
            end
            S_RD_WAIT: r_res <= mk_result(ST_READ, 1'b1, r_item.ridx, i_tbl_rd);
            S_APPLY:   r_res <= ap_res;
            default:   r_res <= r_res;
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ----- design/distance_vector_route_update.sv -----
// Top level of the distance-vector route update block: stream ports, hop
// limit register and output register. Depends on dvr_pkg, dvr_table, dvr_seq.
//
//   Channel  | Direction | Beat contents
//   ---------+-----------+--------------------------------------------------
//   s_axis   | in        | tuser: command; tdata: dest, distance, hop, index
//   m_axis   | out       | tuser: status, valid; tdata: index, dest, dist, hop
//   cfg      | in        | data: hop limit (5 bits)
//
// Install and advertise scan the table one entry per cycle through a single
// memory read port and one destination compare, then apply the update rules.
// Reads go through the read and read-wait states; dropped advertisements and
// unused commands go straight to the result without a table access.
// Reset is synchronous, active low, and empties the table (route count zero).
// A finished result waits in the output register while the next beat is taken.
`default_nettype none

module distance_vector_route_update
    import dvr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input beat
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [1:0]          i_s_axis_tuser,  // [1:0] command
    input  wire logic [31:0]         i_s_axis_tdata,  // [7:0] dest_id, [12:8] distance,
                                                      // [20:13] hop_id, [25:21] read_index
    // Result beat
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    output logic [3:0]               o_m_axis_tuser,  // [2:0] status, [3] entry_valid
    output logic [31:0]              o_m_axis_tdata,  // [4:0] entry_index, [12:5] entry_dest,
                                                      // [17:13] entry_distance, [25:18] entry_hop
    // Hop limit write
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [LIMIT_W-1:0]  i_cfg_data
);

    logic [LIMIT_W-1:0] r_hop_limit;
    logic               r_out_vld;
    t_result            r_out;

    t_item              in_item;
    logic               res_valid;
    logic               res_ready;
    t_result            res;
    t_tbl_req           tbl_req;
    t_entry             tbl_rd;
    logic [CNT_W-1:0]   tbl_count;

    // Unpack the input beat.
    assign in_item.cmd      = i_s_axis_tuser;
    assign in_item.dest     = i_s_axis_tdata[7:0];
    assign in_item.distance = i_s_axis_tdata[12:8];
    assign in_item.hop      = i_s_axis_tdata[20:13];
    assign in_item.ridx     = i_s_axis_tdata[25:21];

    // Hop limit register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop_limit <= HOP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_hop_limit <= i_cfg_data;
        end
    end

    dvr_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rd    (tbl_rd),
        .o_count (tbl_count)
    );

    dvr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_item      (in_item),
        .i_hop_limit (r_hop_limit),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_tbl_req   (tbl_req),
        .i_tbl_rd    (tbl_rd),
        .i_tbl_count (tbl_count)
    );

    // Output register: loads when empty or when its beat is being taken.
    assign res_ready = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    // Pack the result beat.
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = {r_out.valid, r_out.status};
    assign o_m_axis_tdata  = {6'd0, r_out.entry.hop, r_out.entry.distance,
                              r_out.entry.dest, r_out.index};

endmodule

`default_nettype wire
